>>> rtl/core/mpia_pkg.sv
// ============================================================================
// mpia_pkg
// Shared types and constants of the multi-pool index allocator.
// ============================================================================
`default_nettype none

package mpia_pkg;

    localparam int POOL_COUNT = 5;
    localparam int POOL_W     = 3;   // width of the pool selector
    localparam int IDX_W      = 14;  // slot and release index width
    localparam int CFG_W      = 15;  // widest capacity register
    localparam int CNT_W      = 15;  // bump counter width
    localparam int CMP_W      = 17;  // holds any slot count up to 65536

    // capacity register widths and reset values, one per pool
    localparam int CAP_WIDTH [POOL_COUNT] = '{15, 11, 14, 11, 10};
    localparam int CAP_RESET [POOL_COUNT] = '{16384, 1024, 8192, 1024, 512};

    typedef enum logic [0:0] {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_DROPPED   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_POP,
        OP_PUSH,
        OP_BUMP,
        OP_EXHAUST,
        OP_DROP
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DELIVER
    } state_t;

    // per-pool status
    typedef struct packed {
        logic pop_ok;
        logic push_ok;
        logic bump_ok;
    } pool_stat_t;

    // datapath to controller
    typedef struct packed {
        func_t func;
        logic  pool_ok;
        logic  pop_ok;
        logic  push_ok;
        logic  bump_ok;
    } dp_stat_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic exec;
        op_t  op;
        logic load_out;
    } dp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/multi_pool_index_allocator_top.sv
// ============================================================================
// multi_pool_index_allocator_top
// Slot index allocator for five pools, each with a bump counter and a
// last-in-first-out stack of released indices.
// ============================================================================
//
//  Channel  Direction  Signals                     Content
//  -------  ---------  --------------------------  -----------------------------
//  s_*      in         s_tvalid/s_tready/s_tdata   request: alloc or release
//                      s_tuser
//  m_*      out        m_tvalid/m_tready/m_tdata   one result per request
//                      m_tuser
//  cfg_*    in         cfg_we/cfg_index/cfg_data   pool capacity writes
//
//  Each request passes through accept, execute on the pool (counter, stack
//  depth and one memory port) and load of the output register. One request
//  is in flight at a time; the next is taken once the result is loaded.
//  The result for a request shows on m_tvalid once the deliver step loads it.
//  A stalled output holds the result in its register and holds the sequencer
//  in its deliver step. Reset clears counters, stack depths and capacities
//  to their defaults at once; stack memories need no clearing pass.
//
`default_nettype none

module multi_pool_index_allocator_top #(
    parameter int SAMPLED_IMAGE_SLOTS = 16384,
    parameter int SAMPLER_SLOTS       = 1024,
    parameter int STORAGE_IMAGE_SLOTS = 8192,
    parameter int SAMPLED_CUBE_SLOTS  = 1024,
    parameter int STORAGE_CUBE_SLOTS  = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [13:0] release_index, [15:14] zero
    input  wire logic [3:0]  s_tuser,   // [0] func, [3:1] pool
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [13:0] slot_index, [15:14] zero
    output logic      [1:0]  m_tuser,   // [1:0] status
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);

    localparam int IW = mpia_pkg::IDX_W;

    mpia_pkg::dp_cmd_t  cmd;
    mpia_pkg::dp_stat_t stat;
    logic [IW-1:0]      out_slot;
    mpia_pkg::status_t  out_status;
    mpia_pkg::func_t    in_func;

    // unpack the request sideband
    assign in_func = mpia_pkg::func_t'(s_tuser[0]);

    // sequencer: owns the handshakes and picks the pool operation
    mpia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // pools, request register and result registers
    mpia_datapath #(
        .SAMPLED_IMAGE_SLOTS (SAMPLED_IMAGE_SLOTS),
        .SAMPLER_SLOTS       (SAMPLER_SLOTS),
        .STORAGE_IMAGE_SLOTS (STORAGE_IMAGE_SLOTS),
        .SAMPLED_CUBE_SLOTS  (SAMPLED_CUBE_SLOTS),
        .STORAGE_CUBE_SLOTS  (STORAGE_CUBE_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_func    (in_func),
        .in_pool    (s_tuser[3:1]),
        .in_index   (s_tdata[IW-1:0]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .out_slot   (out_slot),
        .out_status (out_status)
    );

    // pad the result to whole bytes
    assign m_tdata = {2'b00, out_slot};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

>>> rtl/core/mpia_pool.sv
// ============================================================================
// mpia_pool
// One pool: capacity register, bump counter, free stack depth and memory.
// ============================================================================
`default_nettype none

module mpia_pool #(
    parameter int SLOTS   = 1024,
    parameter int CAP_W   = 11,
    parameter int CAP_RST = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [mpia_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          pop,
    input  wire logic                          push,
    input  wire logic                          bump,
    input  wire logic [mpia_pkg::IDX_W-1:0]    push_data,
    output mpia_pkg::pool_stat_t               stat,
    output logic      [mpia_pkg::IDX_W-1:0]    count,
    output logic      [mpia_pkg::IDX_W-1:0]    rdata
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW = $clog2(SLOTS + 1);
    localparam int CW = mpia_pkg::CNT_W;
    localparam int MW = mpia_pkg::CMP_W;

    logic [CAP_W-1:0]          cap_reg;
    logic [CAP_W-1:0]          cap_next;
    logic [CW-1:0]             cnt_reg;
    logic [CW-1:0]             cnt_next;
    logic [DW-1:0]             depth_reg;
    logic [DW-1:0]             depth_next;
    logic [DW-1:0]             depth_dec;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic [mpia_pkg::IDX_W-1:0] mem [SLOTS];
    logic [mpia_pkg::IDX_W-1:0] rdata_reg;

    assign depth_dec = depth_reg - DW'(1);
    assign wr_addr   = AW'(depth_reg);
    assign rd_addr   = AW'(depth_dec);

    assign stat.pop_ok  = (depth_reg != '0);
    assign stat.push_ok = (depth_reg != DW'(SLOTS));
    assign stat.bump_ok = (MW'(cnt_reg) < MW'(cap_reg)) && (MW'(cnt_reg) < MW'(SLOTS));

    assign count = cnt_reg[mpia_pkg::IDX_W-1:0];
    assign rdata = rdata_reg;

    always_comb
    begin
        cap_next = cfg_we ? cfg_data[CAP_W-1:0] : cap_reg;
        cnt_next = bump ? cnt_reg + CW'(1) : cnt_reg;
        if (push)
        begin
            depth_next = depth_reg + DW'(1);
        end
        else if (pop)
        begin
            depth_next = depth_dec;
        end
        else
        begin
            depth_next = depth_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_W'(CAP_RST);
            cnt_reg   <= '0;
            depth_reg <= '0;
        end
        else
        begin
            cap_reg   <= cap_next;
            cnt_reg   <= cnt_next;
            depth_reg <= depth_next;
        end
    end

    // free stack storage, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_addr] <= push_data;
        end
        if (pop)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mpia_datapath.sv
// ============================================================================
// mpia_datapath
// Request register, five pools, result and output registers.
// ============================================================================
`default_nettype none

module mpia_datapath #(
    parameter int SAMPLED_IMAGE_SLOTS = 16384,
    parameter int SAMPLER_SLOTS       = 1024,
    parameter int STORAGE_IMAGE_SLOTS = 8192,
    parameter int SAMPLED_CUBE_SLOTS  = 1024,
    parameter int STORAGE_CUBE_SLOTS  = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  mpia_pkg::func_t                    in_func,
    input  wire logic [mpia_pkg::POOL_W-1:0]   in_pool,
    input  wire logic [mpia_pkg::IDX_W-1:0]    in_index,
    input  wire logic                          cfg_we,
    input  wire logic [mpia_pkg::POOL_W-1:0]   cfg_index,
    input  wire logic [mpia_pkg::CFG_W-1:0]    cfg_data,
    input  mpia_pkg::dp_cmd_t                  cmd,
    output mpia_pkg::dp_stat_t                 stat,
    output logic      [mpia_pkg::IDX_W-1:0]    out_slot,
    output mpia_pkg::status_t                  out_status
);

    localparam int NP = mpia_pkg::POOL_COUNT;
    localparam int PW = mpia_pkg::POOL_W;
    localparam int IW = mpia_pkg::IDX_W;

    mpia_pkg::func_t      req_func_reg;
    logic [PW-1:0]        req_pool_reg;
    logic [IW-1:0]        req_index_reg;
    logic                 pool_ok;
    logic [PW-1:0]        pool_sel;

    mpia_pkg::pool_stat_t pstat  [NP];
    logic [IW-1:0]        pcount [NP];
    logic [IW-1:0]        prdata [NP];

    logic [IW-1:0]        res_slot_reg;
    logic [IW-1:0]        res_slot_next;
    mpia_pkg::status_t    res_status_reg;
    mpia_pkg::status_t    res_status_next;
    logic                 res_mem_reg;
    logic [IW-1:0]        out_slot_reg;
    mpia_pkg::status_t    out_status_reg;

    assign pool_ok  = (req_pool_reg < PW'(NP));
    assign pool_sel = pool_ok ? req_pool_reg : '0;

    for (genvar g = 0; g < NP; g++)
    begin : g_pool
        localparam int G_SLOTS = (g == 0) ? SAMPLED_IMAGE_SLOTS :
                                 (g == 1) ? SAMPLER_SLOTS :
                                 (g == 2) ? STORAGE_IMAGE_SLOTS :
                                 (g == 3) ? SAMPLED_CUBE_SLOTS : STORAGE_CUBE_SLOTS;
        logic hit;

        assign hit = cmd.exec && (req_pool_reg == PW'(g));

        mpia_pool #(
            .SLOTS   (G_SLOTS),
            .CAP_W   (mpia_pkg::CAP_WIDTH[g]),
            .CAP_RST (mpia_pkg::CAP_RESET[g])
        ) u_pool (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg_we    (cfg_we && (cfg_index == PW'(g))),
            .cfg_data  (cfg_data),
            .pop       (hit && (cmd.op == mpia_pkg::OP_POP)),
            .push      (hit && (cmd.op == mpia_pkg::OP_PUSH)),
            .bump      (hit && (cmd.op == mpia_pkg::OP_BUMP)),
            .push_data (req_index_reg),
            .stat      (pstat[g]),
            .count     (pcount[g]),
            .rdata     (prdata[g])
        );
    end

    assign stat.func    = req_func_reg;
    assign stat.pool_ok = pool_ok;
    assign stat.pop_ok  = pstat[pool_sel].pop_ok;
    assign stat.push_ok = pstat[pool_sel].push_ok;
    assign stat.bump_ok = pstat[pool_sel].bump_ok;

    always_comb
    begin
        res_slot_next   = '0;
        res_status_next = mpia_pkg::ST_OK;
        unique case (cmd.op)
            mpia_pkg::OP_BUMP:    res_slot_next   = pcount[pool_sel];
            mpia_pkg::OP_EXHAUST: res_status_next = mpia_pkg::ST_EXHAUSTED;
            mpia_pkg::OP_DROP:    res_status_next = mpia_pkg::ST_DROPPED;
            default:              res_status_next = mpia_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_func_reg  <= in_func;
            req_pool_reg  <= in_pool;
            req_index_reg <= in_index;
        end
        if (cmd.exec)
        begin
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
            res_mem_reg    <= (cmd.op == mpia_pkg::OP_POP);
        end
        if (cmd.load_out)
        begin
            out_slot_reg   <= res_mem_reg ? prdata[pool_sel] : res_slot_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_slot   = out_slot_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

>>> rtl/core/mpia_ctrl.sv
// ============================================================================
// mpia_ctrl
// Request sequencer: accept, execute on the selected pool, deliver.
// ============================================================================
`default_nettype none

module mpia_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  mpia_pkg::dp_stat_t stat,
    output mpia_pkg::dp_cmd_t  cmd
);

    mpia_pkg::state_t state_reg;
    mpia_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpia_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.load_req = 1'b0;
        cmd.exec     = 1'b0;
        cmd.op       = mpia_pkg::OP_EXHAUST;
        cmd.load_out = 1'b0;
        in_ready     = 1'b0;

        // decide the operation from the selected pool's status
        priority if (!stat.pool_ok)
        begin
            cmd.op = (stat.func == mpia_pkg::FUNC_RELEASE) ? mpia_pkg::OP_DROP
                                                            : mpia_pkg::OP_EXHAUST;
        end
        else if (stat.func == mpia_pkg::FUNC_ALLOC)
        begin
            cmd.op = stat.pop_ok  ? mpia_pkg::OP_POP  :
                     stat.bump_ok ? mpia_pkg::OP_BUMP : mpia_pkg::OP_EXHAUST;
        end
        else
        begin
            cmd.op = stat.push_ok ? mpia_pkg::OP_PUSH : mpia_pkg::OP_DROP;
        end

        unique case (state_reg)
            mpia_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = mpia_pkg::S_EXEC;
                end
            end
            mpia_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = mpia_pkg::S_DELIVER;
            end
            mpia_pkg::S_DELIVER:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mpia_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mpia_pkg::S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/mpia_checker.sv
// ============================================================================
// mpia_checker
// Port-level checks of the allocator, bound to the top level.
// ============================================================================
`default_nettype none

module mpia_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == mpia_pkg::ST_OK) || (m_tuser == mpia_pkg::ST_EXHAUSTED)
                     || (m_tuser == mpia_pkg::ST_DROPPED))
        else $error("undefined status code");

    // a failed request carries index zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != mpia_pkg::ST_OK) |-> (m_tdata == 16'd0))
        else $error("nonzero index on failed request");

    // one request in flight: s_tready stays low through the execute and deliver steps
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("request accepted while another is in flight");

endmodule

bind multi_pool_index_allocator_top mpia_checker u_mpia_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
